@@ rtl/core/ipsl_pkg.sv @@
// Package for the interval prefix-sum lookup block.
// Holds the operation and status codes and the beat types of both channels.
// No dependencies.
package ipsl_pkg;

  localparam int IDX_W  = 11;
  localparam int ST_W   = 2;
  localparam int FUNC_W = 2;
  localparam int DUR_W  = 16;
  localparam int REP_W  = 16;
  localparam int TIME_W = 32;

  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;

  localparam logic [ST_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [ST_W-1:0] ST_PAST_END = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DUR_W-1:0]  duration;
    logic [REP_W-1:0]  repeat_count;
    logic [TIME_W-1:0] query_time;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic [ST_W-1:0]  status;
  } out_beat_t;

endpackage

@@ rtl/core/ipsl_end_ram.sv @@
// End-time memory of the interval prefix-sum lookup block.
// One write port and one read port, read data registered.
// No dependencies.
module ipsl_end_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/interval_prefix_sum_lookup_top.sv @@
// Interval prefix-sum lookup: cumulative end-time table with upper-bound search.
// Clear completes on acceptance; append multiplies, then saturating-adds and writes.
// Query: accepted, then one memory read per step of the binary search
// (up to ceil(log2(entries)) reads, 10 for 1024), then the output register.
// Single read port, one search probe a cycle; no new beat is taken until a query ends.
// Synchronous active-low reset empties the table; memory contents are not cleared.
module interval_prefix_sum_lookup_top #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ipsl_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output ipsl_pkg::out_beat_t out_beat
);

  import ipsl_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPEND,
    S_SEARCH,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TIME_W-1:0]   run_end_r, run_end_nxt;
  logic [TIME_W-1:0]   prod_r, prod_nxt;
  logic [TIME_W-1:0]   t_r, t_nxt;
  logic [AW-1:0]       lo_r, lo_nxt;
  logic [AW-1:0]       hi_r, hi_nxt;
  logic [AW-1:0]       mid_r, mid_nxt;
  logic [CNT_W-1:0]    res_idx_r, res_idx_nxt;
  logic [ST_W-1:0]     res_st_r, res_st_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_beat_r, out_beat_nxt;

  logic                accept;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [TIME_W-1:0]   wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [TIME_W-1:0]   rd_data;

  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   sat_end;
  logic [CNT_W-1:0]    last_idx;
  logic [AW-1:0]       hi_init;
  logic                gt;
  logic [AW-1:0]       lo_s;
  logic [AW-1:0]       hi_s;
  logic [AW-1:0]       mid_s;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign sum      = {1'b0, run_end_r} + {1'b0, prod_r};
  assign sat_end  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign last_idx = count_r - CNT_W'(1);
  assign hi_init  = last_idx[AW-1:0];

  assign gt    = rd_data > t_r;
  assign lo_s  = gt ? lo_r : mid_r + AW'(1);
  assign hi_s  = gt ? mid_r : hi_r;
  assign mid_s = lo_s + ((hi_s - lo_s) >> 1);

  assign wr_addr = count_r[AW-1:0];
  assign wr_data = sat_end;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    run_end_nxt   = run_end_r;
    prod_nxt      = prod_r;
    t_nxt         = t_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_idx_nxt   = res_idx_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = mid_s;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_beat.func)
            FN_CLEAR: begin
              count_nxt   = '0;
              run_end_nxt = TIME_W'(1);
            end
            FN_APPEND: begin
              if (count_r < CNT_MAX) begin
                prod_nxt  = TIME_W'(in_beat.duration) * TIME_W'(in_beat.repeat_count);
                state_nxt = S_APPEND;
              end
            end
            FN_QUERY: begin
              t_nxt = in_beat.query_time;
              if (count_r == '0) begin
                res_idx_nxt = '0;
                res_st_nxt  = ST_EMPTY;
                state_nxt   = S_OUT;
              end else if (run_end_r <= in_beat.query_time) begin
                res_idx_nxt = '0;
                res_st_nxt  = ST_PAST_END;
                state_nxt   = S_OUT;
              end else if (hi_init == '0) begin
                res_idx_nxt = CNT_W'(1);
                res_st_nxt  = ST_FOUND;
                state_nxt   = S_OUT;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = hi_init;
                mid_nxt   = hi_init >> 1;
                rd_addr   = hi_init >> 1;
                rd_en     = 1'b1;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_APPEND: begin
        wr_en       = 1'b1;
        run_end_nxt = sat_end;
        count_nxt   = count_r + CNT_W'(1);
        state_nxt   = S_IDLE;
      end
      S_SEARCH: begin
        lo_nxt = lo_s;
        hi_nxt = hi_s;
        if (lo_s < hi_s) begin
          mid_nxt = mid_s;
          rd_en   = 1'b1;
        end else begin
          res_idx_nxt = CNT_W'(lo_s) + CNT_W'(1);
          res_st_nxt  = ST_FOUND;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_beat_nxt.entry_index = IDX_W'(res_idx_r);
          out_beat_nxt.status      = res_st_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    t_r        <= t_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    res_idx_r  <= res_idx_nxt;
    res_st_r   <= res_st_nxt;
    out_beat_r <= out_beat_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      run_end_r   <= TIME_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      run_end_r   <= run_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  ipsl_end_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (TIME_W)
  ) u_end_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("entry count beyond table depth");

  a_run_end_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    run_end_r != '0)
    else $error("running end dropped to zero");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> lo_r <= mid_r && mid_r < hi_r && CNT_W'(hi_r) < count_r)
    else $error("search window out of range");

  a_found_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && res_st_r == ST_FOUND |-> res_idx_r != '0 && res_idx_r <= count_r)
    else $error("found index outside stored entries");

  a_append_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPEND |=> count_r == $past(count_r) + CNT_W'(1) && state_r == S_IDLE)
    else $error("append did not advance entry count");

endmodule

@@ tb/ipsl_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the interval prefix-sum lookup testbench: tracks the end-time table
// and checks each lookup result in order. Depends on ipsl_pkg.
package ipsl_tb_pkg;
  import ipsl_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  class lookup_tracker;
    logic [TIME_W-1:0] end_times [TABLE_DEPTH];
    logic [TIME_W-1:0] running_end;
    int unsigned entry_count;
    out_beat_t expected_lookups [$];
    int unsigned mismatches;

    function new();
      running_end = 1;
      entry_count = 0;
      mismatches = 0;
    endfunction

    function out_beat_t locate_entry(logic [TIME_W-1:0] t);
      out_beat_t r;
      r.entry_index = '0;
      r.status = ST_FOUND;
      if (entry_count == 0) begin
        r.status = ST_EMPTY;
      end else if (end_times[entry_count-1] <= t) begin
        r.status = ST_PAST_END;
      end else begin
        for (int i = 0; i < entry_count; i++) begin
          if (end_times[i] > t) begin
            r.entry_index = IDX_W'(i + 1);
            break;
          end
        end
      end
      return r;
    endfunction

    function void note_request(in_beat_t b);
      logic [TIME_W:0] total;
      case (b.func)
        FN_CLEAR: begin
          running_end = 1;
          entry_count = 0;
        end
        FN_APPEND: begin
          if (entry_count < TABLE_DEPTH) begin
            total = {1'b0, running_end} + (33'(b.duration) * 33'(b.repeat_count));
            running_end = total[TIME_W] ? '1 : total[TIME_W-1:0];
            end_times[entry_count] = running_end;
            entry_count++;
          end
        end
        FN_QUERY: expected_lookups.push_back(locate_entry(b.query_time));
        default: ;
      endcase
    endfunction

    function void check_lookup(out_beat_t got);
      out_beat_t want;
      if (expected_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with no lookup pending: index %0d status %0d",
                   got.entry_index, got.status);
      end else begin
        want = expected_lookups.pop_front();
        if (got.entry_index !== want.entry_index || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("lookup mismatch: expected index %0d status %0d, got index %0d status %0d",
                     want.entry_index, want.status, got.entry_index, got.status);
        end
      end
    endfunction
  endclass

endpackage

@@ tb/tb_interval_prefix_sum_lookup_top.sv @@
`timescale 1ns / 1ps
// Testbench for interval_prefix_sum_lookup_top: directed, table-fill and random
// clear/append/query traffic with idle gaps and back-pressure. Depends on ipsl_pkg, ipsl_tb_pkg.
module tb_interval_prefix_sum_lookup_top;
  import ipsl_pkg::*;
  import ipsl_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 550;
  localparam int FILL_ENTRIES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_beat;

  bit quiet = 1'b0;
  int unsigned items_sent = 0;
  lookup_tracker sb = new();

  interval_prefix_sum_lookup_top #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat(out_beat)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DUR_W-1:0] pick_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 18) return '1;
    if (r < 70) return DUR_W'($urandom_range(1, 20));
    return DUR_W'($urandom);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned i;
    logic [TIME_W-1:0] e;
    logic [TIME_W-1:0] last;
    if (sb.entry_count == 0) return $urandom;
    i = $urandom_range(0, sb.entry_count - 1);
    e = sb.end_times[i];
    last = sb.end_times[sb.entry_count-1];
    case ($urandom_range(0, 9))
      0: return e - 1;
      1, 2: return e;
      3: return e + 1;
      4: return '0;
      5: return $urandom;
      6: return '1;
      default: return $urandom_range(0, last);
    endcase
  endfunction

  task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic [DUR_W-1:0] dur,
                           input logic [REP_W-1:0] reps, input logic [TIME_W-1:0] t);
    in_beat_t b;
    int idle;
    b.func = fn;
    b.duration = dur;
    b.repeat_count = reps;
    b.query_time = t;
    idle = quiet ? 0 : pick_idle();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_request(b);
    if (fn != FN_UNUSED) items_sent++;
  endtask

  task automatic clear_table();
    send_beat(FN_CLEAR, $urandom, $urandom, $urandom);
  endtask

  task automatic append_entry(input logic [DUR_W-1:0] dur, input logic [REP_W-1:0] reps);
    send_beat(FN_APPEND, dur, reps, $urandom);
  endtask

  task automatic lookup(input logic [TIME_W-1:0] t);
    send_beat(FN_QUERY, $urandom, $urandom, t);
  endtask

  task automatic run_random();
    int unsigned n;
    while (items_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          send_beat(FN_UNUSED, $urandom, $urandom, $urandom);
          send_beat(2'($urandom), $urandom, $urandom, $urandom);
        end
        3: begin
          clear_table();
          repeat ($urandom_range(1, 3)) lookup($urandom);
        end
        4, 5, 6: begin
          repeat ($urandom_range(1, 8)) lookup(pick_time());
        end
        default: begin
          if ($urandom_range(0, 1)) clear_table();
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
          repeat (n) append_entry(pick_span(), pick_span());
          repeat ($urandom_range(1, 15)) lookup(pick_time());
        end
      endcase
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_lookup(out_beat);
  end

  initial begin : result_backpressure
    int stall_len;
    wait (rst_n === 1'b1);
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      if (!quiet) begin
        stall_len = pick_idle();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    lookup('0);
    send_beat(FN_UNUSED, '1, '1, '1);
    append_entry('0, '1);
    lookup('0);
    lookup(32'd1);
    append_entry('1, '0);
    append_entry(16'd3, 16'd5);
    lookup('0);
    lookup(32'd1);
    lookup(32'd15);
    lookup(32'd16);
    append_entry('1, '1);
    append_entry('1, '1);
    append_entry(16'd1, 16'd1);
    lookup(32'hFFFF_FFFE);
    lookup('1);
    lookup(32'd4294836240);
    clear_table();
    lookup('1);
    send_beat(FN_UNUSED, '0, '0, '0);
    clear_table();

    // fill a long run of entries back to back
    quiet = 1'b1;
    repeat (FILL_ENTRIES) append_entry(DUR_W'($urandom_range(1, 255)),
                                       REP_W'($urandom_range(1, 255)));
    quiet = 1'b0;
    lookup(sb.end_times[sb.entry_count-1] - 1);
    lookup(sb.end_times[sb.entry_count-1]);
    lookup(sb.end_times[sb.entry_count-2]);
    lookup(sb.end_times[0] - 1);
    repeat (40) lookup(pick_time());
    clear_table();

    run_random();

    in_valid <= 1'b0;
    while (sb.expected_lookups.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_lookups.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ipsl_pkg.sv
rtl/core/ipsl_end_ram.sv
rtl/core/interval_prefix_sum_lookup_top.sv
tb/ipsl_tb_pkg.sv
tb/tb_interval_prefix_sum_lookup_top.sv
